// File: sv/sxd_pkg.sv
`timescale 1ns / 1ps

package sxd_pkg;

    // symbol tables: 16 x 16 entries, row stride set at run time
    localparam int ALPHABET_MAX = 16;
    localparam int TBL_DEPTH    = ALPHABET_MAX * ALPHABET_MAX;
    localparam int TBL_AW       = $clog2(TBL_DEPTH);

    // defaults for the top level sizing parameters
    localparam int SEASON_MAX_DEF   = 64;
    localparam int RESIDUAL_MAX_DEF = 64;

    // field widths
    localparam int CMD_W   = 2;
    localparam int SYM_W   = 4;
    localparam int VAL_W   = 16;
    localparam int ALPHA_W = 5;
    localparam int LEN_W   = 7;
    localparam int RATIO_W = 16;
    localparam int SUM_W   = 48;
    localparam int DIST_W  = 63;

    // shared multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // item commands
    localparam logic [CMD_W-1:0] CMD_RES_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEA_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PAIR      = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RES_ALPHA = 3'd0;
    localparam logic [2:0] REG_SEA_ALPHA = 3'd1;
    localparam logic [2:0] REG_SEA_LEN   = 3'd2;
    localparam logic [2:0] REG_RES_LEN   = 3'd3;
    localparam logic [2:0] REG_RATIO     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RES,
        ST_RUN,
        ST_DRAIN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FIN
    } seq_state_t;

    typedef enum logic [1:0] {
        MK_NONE,
        MK_SQ,
        MK_LO,
        MK_HI
    } mac_kind_t;

    // request from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic             sq_valid;
        logic [VAL_W-1:0] sq_value;
        logic             mul_lo;
        logic             mul_hi;
    } mac_op_t;

    typedef struct packed {
        logic [SYM_W-1:0] x;
        logic [SYM_W-1:0] y;
    } sym_pair_t;

    // table address row * alpha + col, wrapped to the table depth
    function automatic logic [TBL_AW-1:0] tbl_addr(
        input logic [SYM_W-1:0]   row,
        input logic [ALPHA_W-1:0] alpha,
        input logic [SYM_W-1:0]   col
    );
        logic [SYM_W+ALPHA_W:0] full;
        full = (SYM_W+ALPHA_W+1)'(row) * (SYM_W+ALPHA_W+1)'(alpha)
             + (SYM_W+ALPHA_W+1)'(col);
        return full[TBL_AW-1:0];
    endfunction

endpackage

// File: sv/season_residual_sax_distance_top.sv
`timescale 1ns / 1ps

// Lower-bound distance between two season-plus-residual symbolic series, Q4.12
// tables in, Q.24 distance out. Table writes (tuser 0 residual, 1 seasonal) and
// seasonal pairs are taken directly while idle. A residual pair stalls the input
// for a pass in which one shared multiplier squares one seasonal/residual table
// sum per cycle, followed by a short pipeline drain. After the last residual pair
// of a series the same multiplier scales the sum by length_ratio in two partial
// products, and the block then offers one distance item; it also
// waits while an earlier distance item is still unaccepted. Tables and stored
// pairs are not cleared at reset and must be written before use.
module season_residual_sax_distance_top #(
    parameter int SEASON_MAX   = sxd_pkg::SEASON_MAX_DEF,
    parameter int RESIDUAL_MAX = sxd_pkg::RESIDUAL_MAX_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // table_index [7:0], table_value [23:8], x_symbol [27:24], y_symbol [31:28]
    input  logic [31:0]                  s_tdata,
    // command [1:0]
    input  logic [sxd_pkg::CMD_W-1:0]    s_tuser,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // distance [62:0], bit 63 zero
    output logic [63:0]                  m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sxd_pkg::APB_AW-1:0]   paddr,
    input  logic [sxd_pkg::APB_DW-1:0]   pwdata,
    output logic [sxd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    import sxd_pkg::*;

    logic [ALPHA_W-1:0] res_alpha_reg;
    logic [ALPHA_W-1:0] sea_alpha_reg;
    logic [LEN_W-1:0]   sea_len_reg;
    logic [LEN_W-1:0]   res_len_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [2:0]         reg_idx;
    logic               cfg_write;

    logic [TBL_AW-1:0]  in_index;
    logic [VAL_W-1:0]   in_value;
    logic [SYM_W-1:0]   in_x;
    logic [SYM_W-1:0]   in_y;
    logic               in_fire;
    logic               in_ready;

    logic [TBL_AW-1:0]  res_raddr_a, res_raddr_b;
    logic [VAL_W-1:0]   res_rdata_a, res_rdata_b;
    logic [TBL_AW-1:0]  sea_raddr_a, sea_raddr_b;
    logic [VAL_W-1:0]   sea_rdata_a, sea_rdata_b;

    mac_op_t            mac_op;
    logic               mac_busy;
    logic               mac_res_valid;
    logic [DIST_W-1:0]  mac_res_distance;

    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_alpha_reg <= ALPHA_W'(ALPHABET_MAX);
            sea_alpha_reg <= ALPHA_W'(ALPHABET_MAX);
            sea_len_reg   <= LEN_W'(1);
            res_len_reg   <= LEN_W'(1);
            ratio_reg     <= RATIO_W'(1);
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_RES_ALPHA: res_alpha_reg <= pwdata[ALPHA_W-1:0];
                REG_SEA_ALPHA: sea_alpha_reg <= pwdata[ALPHA_W-1:0];
                REG_SEA_LEN:   sea_len_reg   <= pwdata[LEN_W-1:0];
                REG_RES_LEN:   res_len_reg   <= pwdata[LEN_W-1:0];
                REG_RATIO:     ratio_reg     <= pwdata[RATIO_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RES_ALPHA: prdata = APB_DW'(res_alpha_reg);
            REG_SEA_ALPHA: prdata = APB_DW'(sea_alpha_reg);
            REG_SEA_LEN:   prdata = APB_DW'(sea_len_reg);
            REG_RES_LEN:   prdata = APB_DW'(res_len_reg);
            REG_RATIO:     prdata = APB_DW'(ratio_reg);
            default:       prdata = '0;
        endcase
    end

    // input item fields
    assign in_index = s_tdata[7:0];
    assign in_value = s_tdata[23:8];
    assign in_x     = s_tdata[27:24];
    assign in_y     = s_tdata[31:28];
    assign s_tready = in_ready;
    assign in_fire  = s_tvalid && in_ready;

    // distance tables
    sxd_dpram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (VAL_W)
    ) u_res_table (
        .aclk    (aclk),
        .we      (in_fire && s_tuser == CMD_RES_WRITE),
        .waddr   (in_index),
        .wdata   (in_value),
        .raddr_a (res_raddr_a),
        .raddr_b (res_raddr_b),
        .rdata_a (res_rdata_a),
        .rdata_b (res_rdata_b)
    );

    sxd_dpram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (VAL_W)
    ) u_sea_table (
        .aclk    (aclk),
        .we      (in_fire && s_tuser == CMD_SEA_WRITE),
        .waddr   (in_index),
        .wdata   (in_value),
        .raddr_a (sea_raddr_a),
        .raddr_b (sea_raddr_b),
        .rdata_a (sea_rdata_a),
        .rdata_b (sea_rdata_b)
    );

    sxd_seq #(
        .SEASON_MAX   (SEASON_MAX),
        .RESIDUAL_MAX (RESIDUAL_MAX)
    ) u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_fire           (in_fire),
        .command           (s_tuser),
        .x_symbol          (in_x),
        .y_symbol          (in_y),
        .residual_alphabet (res_alpha_reg),
        .seasonal_alphabet (sea_alpha_reg),
        .season_length     (sea_len_reg),
        .residual_length   (res_len_reg),
        .in_ready          (in_ready),
        .res_raddr_a       (res_raddr_a),
        .res_raddr_b       (res_raddr_b),
        .res_rdata_a       (res_rdata_a),
        .res_rdata_b       (res_rdata_b),
        .sea_raddr_a       (sea_raddr_a),
        .sea_raddr_b       (sea_raddr_b),
        .sea_rdata_a       (sea_rdata_a),
        .sea_rdata_b       (sea_rdata_b),
        .mac_busy          (mac_busy),
        .out_full          (m_tvalid_reg),
        .mac_op            (mac_op)
    );

    sxd_mac u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (mac_op),
        .length_ratio (ratio_reg),
        .busy         (mac_busy),
        .res_valid    (mac_res_valid),
        .res_distance (mac_res_distance)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (mac_res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_res_valid) begin
            m_tdata_reg <= {1'b0, mac_res_distance};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/sxd_dpram.sv
`timescale 1ns / 1ps

module sxd_dpram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: sv/sxd_mac.sv
`timescale 1ns / 1ps

module sxd_mac (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sxd_pkg::mac_op_t                 op,
    input  logic [sxd_pkg::RATIO_W-1:0]      length_ratio,
    output logic                             busy,
    output logic                             res_valid,
    output logic [sxd_pkg::DIST_W-1:0]       res_distance
);

    import sxd_pkg::*;

    logic [MUL_A_W-1:0] opnd_a_reg, opnd_a_next;
    logic [MUL_B_W-1:0] opnd_b_reg, opnd_b_next;
    mac_kind_t          okind_reg, okind_next;
    logic [PROD_W-1:0]  prod_reg;
    mac_kind_t          pkind_reg;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic [PROD_W-1:0]  lo_reg;
    logic [SUM_W:0]     acc_sum;
    logic [63:0]        total;

    // operand select: square, then low and high partial products of the scaling
    always_comb begin
        opnd_a_next = opnd_a_reg;
        opnd_b_next = opnd_b_reg;
        okind_next  = MK_NONE;
        if (op.sq_valid) begin
            opnd_a_next = MUL_A_W'(op.sq_value);
            opnd_b_next = op.sq_value;
            okind_next  = MK_SQ;
        end else if (op.mul_lo) begin
            opnd_a_next = acc_reg[MUL_A_W-1:0];
            opnd_b_next = length_ratio;
            okind_next  = MK_LO;
        end else if (op.mul_hi) begin
            opnd_a_next = MUL_A_W'(acc_reg[SUM_W-1:MUL_A_W]);
            opnd_b_next = length_ratio;
            okind_next  = MK_HI;
        end
    end

    // saturating accumulate and final product assembly
    assign acc_sum = {1'b0, acc_reg} + (SUM_W+1)'(prod_reg[MUL_A_W-1:0]);
    assign total   = {prod_reg[MUL_A_W-1:0], 32'b0} + 64'(lo_reg);

    always_comb begin
        acc_next = acc_reg;
        case (pkind_reg)
            MK_SQ:   acc_next = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
            MK_HI:   acc_next = '0;
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            okind_reg <= MK_NONE;
            pkind_reg <= MK_NONE;
            acc_reg   <= '0;
        end else begin
            okind_reg <= okind_next;
            pkind_reg <= okind_reg;
            acc_reg   <= acc_next;
        end
    end

    // operand and product registers
    always_ff @(posedge aclk) begin
        opnd_a_reg <= opnd_a_next;
        opnd_b_reg <= opnd_b_next;
        prod_reg   <= opnd_a_reg * PROD_W'(opnd_b_reg);
        if (pkind_reg == MK_LO) begin
            lo_reg <= prod_reg;
        end
    end

    assign busy         = (okind_reg != MK_NONE) || (pkind_reg != MK_NONE);
    assign res_valid    = (pkind_reg == MK_HI);
    assign res_distance = total[63] ? {DIST_W{1'b1}} : total[DIST_W-1:0];

endmodule

// File: sv/sxd_seq.sv
`timescale 1ns / 1ps

module sxd_seq #(
    parameter int SEASON_MAX   = sxd_pkg::SEASON_MAX_DEF,
    parameter int RESIDUAL_MAX = sxd_pkg::RESIDUAL_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic [sxd_pkg::CMD_W-1:0]     command,
    input  logic [sxd_pkg::SYM_W-1:0]     x_symbol,
    input  logic [sxd_pkg::SYM_W-1:0]     y_symbol,
    input  logic [sxd_pkg::ALPHA_W-1:0]   residual_alphabet,
    input  logic [sxd_pkg::ALPHA_W-1:0]   seasonal_alphabet,
    input  logic [sxd_pkg::LEN_W-1:0]     season_length,
    input  logic [sxd_pkg::LEN_W-1:0]     residual_length,
    output logic                          in_ready,
    output logic [sxd_pkg::TBL_AW-1:0]    res_raddr_a,
    output logic [sxd_pkg::TBL_AW-1:0]    res_raddr_b,
    input  logic [sxd_pkg::VAL_W-1:0]     res_rdata_a,
    input  logic [sxd_pkg::VAL_W-1:0]     res_rdata_b,
    output logic [sxd_pkg::TBL_AW-1:0]    sea_raddr_a,
    output logic [sxd_pkg::TBL_AW-1:0]    sea_raddr_b,
    input  logic [sxd_pkg::VAL_W-1:0]     sea_rdata_a,
    input  logic [sxd_pkg::VAL_W-1:0]     sea_rdata_b,
    input  logic                          mac_busy,
    input  logic                          out_full,
    output sxd_pkg::mac_op_t              mac_op
);

    import sxd_pkg::*;

    localparam int PAIR_AW = (SEASON_MAX > 1) ? $clog2(SEASON_MAX) : 1;
    localparam int SLEN_W  = $clog2(SEASON_MAX + 1);
    localparam int RLEN_W  = $clog2(RESIDUAL_MAX + 1);
    localparam int POS_W   = $clog2(SEASON_MAX + RESIDUAL_MAX + 1);

    seq_state_t         state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PAIR_AW-1:0] l_reg, l_next;
    logic               done_reg, done_next;
    logic               v1_reg, v1_next;
    logic               v2_reg;
    logic [VAL_W-1:0]   res_f_reg;
    logic [VAL_W-1:0]   res_i_reg;
    sym_pair_t          pair_mem [SEASON_MAX];
    sym_pair_t          pair_q_reg;
    logic               pair_we;

    logic [SLEN_W-1:0]  slen;
    logic [RLEN_W-1:0]  rlen;
    logic               pos_store;
    logic               last_pair;
    logic               l_last;

    logic signed [VAL_W:0] fwd_sum;
    logic signed [VAL_W:0] inv_sum;
    logic                  fwd_pos;
    logic                  inv_pos;

    // lengths clamped to the supported range
    always_comb begin
        if (season_length == '0) begin
            slen = SLEN_W'(1);
        end else if (32'(season_length) > 32'(SEASON_MAX)) begin
            slen = SLEN_W'(SEASON_MAX);
        end else begin
            slen = SLEN_W'(season_length);
        end
        if (residual_length == '0) begin
            rlen = RLEN_W'(1);
        end else if (32'(residual_length) > 32'(RESIDUAL_MAX)) begin
            rlen = RLEN_W'(RESIDUAL_MAX);
        end else begin
            rlen = RLEN_W'(residual_length);
        end
    end

    assign pos_store = 32'(pos_reg) < 32'(slen);
    assign last_pair = (32'(pos_reg) + 32'd1) >= (32'(slen) + 32'(rlen));
    assign l_last    = 32'(l_reg) == (32'(slen) - 32'd1);

    // residual entries come straight from the incoming pair
    assign res_raddr_a = tbl_addr(x_symbol, residual_alphabet, y_symbol);
    assign res_raddr_b = tbl_addr(y_symbol, residual_alphabet, x_symbol);

    // seasonal entries from the stored pair in flight
    assign sea_raddr_a = tbl_addr(pair_q_reg.x, seasonal_alphabet, pair_q_reg.y);
    assign sea_raddr_b = tbl_addr(pair_q_reg.y, seasonal_alphabet, pair_q_reg.x);

    // forward sum first, transposed sum only when forward is not positive
    assign fwd_sum = $signed({sea_rdata_a[VAL_W-1], sea_rdata_a})
                   + $signed({res_f_reg[VAL_W-1], res_f_reg});
    assign inv_sum = $signed({sea_rdata_b[VAL_W-1], sea_rdata_b})
                   + $signed({res_i_reg[VAL_W-1], res_i_reg});
    assign fwd_pos = !fwd_sum[VAL_W] && (fwd_sum != '0);
    assign inv_pos = !inv_sum[VAL_W] && (inv_sum != '0);

    always_comb begin
        mac_op.sq_valid = v2_reg && (fwd_pos || inv_pos);
        mac_op.sq_value = fwd_pos ? fwd_sum[VAL_W-1:0] : inv_sum[VAL_W-1:0];
        mac_op.mul_lo   = (state_reg == ST_MUL_LO);
        mac_op.mul_hi   = (state_reg == ST_MUL_HI);
    end

    assign in_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        l_next     = l_reg;
        done_next  = done_reg;
        v1_next    = 1'b0;
        pair_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && command == CMD_PAIR) begin
                    if (pos_store) begin
                        pair_we  = 1'b1;
                        pos_next = pos_reg + POS_W'(1);
                    end else begin
                        done_next  = last_pair;
                        pos_next   = last_pair ? '0 : pos_reg + POS_W'(1);
                        l_next     = '0;
                        state_next = ST_RES;
                    end
                end
            end
            ST_RES: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                v1_next = 1'b1;
                if (l_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    l_next = l_reg + PAIR_AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg && !mac_busy) begin
                    if (!done_reg) begin
                        state_next = ST_IDLE;
                    end else if (!out_full) begin
                        state_next = ST_MUL_LO;
                    end
                end
            end
            ST_MUL_LO: begin
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!mac_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            l_reg     <= '0;
            done_reg  <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            l_reg     <= l_next;
            done_reg  <= done_next;
            v1_reg    <= v1_next;
            v2_reg    <= v1_reg;
        end
    end

    // residual entries held for the whole pass
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RES) begin
            res_f_reg <= res_rdata_a;
            res_i_reg <= res_rdata_b;
        end
    end

    // stored seasonal pairs
    always_ff @(posedge aclk) begin
        if (pair_we) begin
            pair_mem[pos_reg[PAIR_AW-1:0]] <= '{x: x_symbol, y: y_symbol};
        end
        pair_q_reg <= pair_mem[l_reg];
    end

endmodule
